@@ rtl/gearcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// gearcdc_pkg
// Shared types, constants and the gear table for the gear-hash chunker.
// ----------------------------------------------------------------------------
`default_nettype none

package gearcdc_pkg;

    localparam int LENGTH_BITS  = 24;
    localparam int SIZE_W       = 24;
    localparam int MASK_BITS_W  = 6;
    localparam int CHUNK_W      = 24;
    localparam int BYTE_W       = 8;
    localparam int FP_W         = 64;
    localparam int GEAR_ENTRIES = 256;
    localparam int CFG_INDEX_W  = 3;
    localparam int CMP_W        = (LENGTH_BITS > SIZE_W) ? LENGTH_BITS : SIZE_W;

    localparam logic [FP_W-1:0] GEAR_SEED = 64'h1234_5678_9ABC_DEF0;
    localparam logic [FP_W-1:0] GEAR_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [FP_W-1:0] GEAR_MUL1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [FP_W-1:0] GEAR_MUL2 = 64'h94D0_49BB_1331_11EB;

    localparam logic [SIZE_W-1:0]      RST_MIN_LEN    = 24'd2048;
    localparam logic [SIZE_W-1:0]      RST_AVG_LEN    = 24'd8192;
    localparam logic [SIZE_W-1:0]      RST_MAX_LEN    = 24'd65536;
    localparam logic [MASK_BITS_W-1:0] RST_SMALL_BITS = 6'd15;
    localparam logic [MASK_BITS_W-1:0] RST_LARGE_BITS = 6'd11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_LEN         = 3'd0,
        CFG_AVG_LEN         = 3'd1,
        CFG_MAX_LEN         = 3'd2,
        CFG_SMALL_MASK_BITS = 3'd3,
        CFG_LARGE_MASK_BITS = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [SIZE_W-1:0]      min_len;
        logic [SIZE_W-1:0]      avg_len;
        logic [SIZE_W-1:0]      max_len;
        logic [MASK_BITS_W-1:0] small_mask_bits;
        logic [MASK_BITS_W-1:0] large_mask_bits;
    } t_cfg;

    typedef struct packed {
        logic                   cut;
        logic [FP_W-1:0]        fp;
        logic [LENGTH_BITS-1:0] len;
    } t_step;

    typedef logic [GEAR_ENTRIES-1:0][FP_W-1:0] t_gear_rom;

    // splitmix64 sequence from the seed, evaluated at elaboration only
    function automatic t_gear_rom build_gear_rom();
        t_gear_rom       rom;
        logic [FP_W-1:0] acc;
        logic [FP_W-1:0] z;
        acc = GEAR_SEED;
        for (int k = 0; k < GEAR_ENTRIES; k++) begin
            acc = acc + GEAR_STEP;
            z   = acc;
            z   = (z ^ (z >> 30)) * GEAR_MUL1;
            z   = (z ^ (z >> 27)) * GEAR_MUL2;
            rom[k] = z ^ (z >> 31);
        end
        return rom;
    endfunction

    localparam t_gear_rom GEAR_ROM = build_gear_rom();

    function automatic logic [FP_W-1:0] low_ones(input logic [MASK_BITS_W-1:0] bits);
        return (FP_W'(1) << bits) - FP_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/gearcdc_cut_logic.sv @@
// ----------------------------------------------------------------------------
// gearcdc_cut_logic
// Fingerprint update and cut decision for one byte (combinational).
// ----------------------------------------------------------------------------
`default_nettype none

module gearcdc_cut_logic (
    input  wire gearcdc_pkg::t_cfg                            i_cfg,
    input  wire logic [gearcdc_pkg::FP_W-1:0]                 i_fp,
    input  wire logic [gearcdc_pkg::LENGTH_BITS-1:0]          i_len,
    input  wire logic [gearcdc_pkg::BYTE_W-1:0]               i_byte,
    input  wire logic                                         i_eos,
    output gearcdc_pkg::t_step                                o_step
);

    logic [gearcdc_pkg::FP_W-1:0]        fp_sum;
    logic [gearcdc_pkg::LENGTH_BITS-1:0] len_inc;
    logic [gearcdc_pkg::CMP_W-1:0]       len_cmp;
    logic [gearcdc_pkg::FP_W-1:0]        mask;
    logic                                hash_cut;

    always_comb begin
        fp_sum  = (i_fp << 1) + gearcdc_pkg::GEAR_ROM[i_byte];
        len_inc = i_len + gearcdc_pkg::LENGTH_BITS'(1);
        len_cmp = gearcdc_pkg::CMP_W'(len_inc);

        // strict mask below the average size, loose from it on
        if (len_cmp < gearcdc_pkg::CMP_W'(i_cfg.avg_len)) begin
            mask = gearcdc_pkg::low_ones(i_cfg.small_mask_bits);
        end else begin
            mask = gearcdc_pkg::low_ones(i_cfg.large_mask_bits);
        end

        hash_cut = (len_cmp >= gearcdc_pkg::CMP_W'(i_cfg.min_len))
                   && ((fp_sum & mask) == '0);

        o_step.cut = hash_cut
                     || (len_cmp >= gearcdc_pkg::CMP_W'(i_cfg.max_len))
                     || (len_inc == '1)
                     || i_eos;
        o_step.fp  = fp_sum;
        o_step.len = len_inc;
    end

endmodule

`default_nettype wire

@@ rtl/gear_hash_content_defined_chunker_core.sv @@
// ----------------------------------------------------------------------------
// gear_hash_content_defined_chunker_core
// Gear-hash content-defined chunker: one byte per item, one chunk length per cut.
// ----------------------------------------------------------------------------
// A byte accepted is held in the input stage and hashed once the result register
//   is free; its chunk length, if it ends a chunk, is registered onto o_m_axis_tdata.
// Throughput: one byte per cycle while the chunk length output is not stalled, set
//   by the fingerprint loop (gear ROM read, 64-bit shift-add and mask test, combinational).
// Reset: synchronous, active low; clears fingerprint, length, valid flags and
//   loads the default sizes and mask bit counts.
`default_nettype none

module gear_hash_content_defined_chunker_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input bytes
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [7:0]                             i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic                                   i_s_axis_tlast,  // end_of_stream
    // chunk lengths
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic [23:0]                                 o_m_axis_tdata,  // [23:0] chunk_length
    // register writes
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [gearcdc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [gearcdc_pkg::SIZE_W-1:0]         i_cfg_data
);

    gearcdc_pkg::t_cfg                   r_cfg, n_cfg;
    logic                                r_in_valid, n_in_valid;
    logic [gearcdc_pkg::BYTE_W-1:0]      r_in_byte, n_in_byte;
    logic                                r_in_eos, n_in_eos;
    logic [gearcdc_pkg::FP_W-1:0]        r_fp, n_fp;
    logic [gearcdc_pkg::LENGTH_BITS-1:0] r_len, n_len;
    logic                                r_out_valid, n_out_valid;
    logic [gearcdc_pkg::CHUNK_W-1:0]     r_out_len, n_out_len;

    gearcdc_pkg::t_step step;
    logic               out_free;
    logic               proc_fire;
    logic               in_fire;

    gearcdc_cut_logic u_cut (
        .i_cfg  (r_cfg),
        .i_fp   (r_fp),
        .i_len  (r_len),
        .i_byte (r_in_byte),
        .i_eos  (r_in_eos),
        .o_step (step)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc_fire       = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || proc_fire;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_len;

    // register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gearcdc_pkg::CFG_MIN_LEN:         n_cfg.min_len = i_cfg_data;
                gearcdc_pkg::CFG_AVG_LEN:         n_cfg.avg_len = i_cfg_data;
                gearcdc_pkg::CFG_MAX_LEN:         n_cfg.max_len = i_cfg_data;
                gearcdc_pkg::CFG_SMALL_MASK_BITS:
                    n_cfg.small_mask_bits = i_cfg_data[gearcdc_pkg::MASK_BITS_W-1:0];
                gearcdc_pkg::CFG_LARGE_MASK_BITS:
                    n_cfg.large_mask_bits = i_cfg_data[gearcdc_pkg::MASK_BITS_W-1:0];
                default:                          n_cfg = r_cfg;
            endcase
        end
    end

    // input stage and chunk state
    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        n_in_eos   = r_in_eos;
        n_fp       = r_fp;
        n_len      = r_len;
        if (proc_fire) begin
            n_in_valid = 1'b0;
            // clear the running chunk on a cut
            n_fp  = step.cut ? '0 : step.fp;
            n_len = step.cut ? '0 : step.len;
        end
        if (in_fire) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_s_axis_tdata[gearcdc_pkg::BYTE_W-1:0];
            n_in_eos   = i_s_axis_tlast;
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_len   = r_out_len;
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (proc_fire && step.cut) begin
            n_out_valid = 1'b1;
            n_out_len   = gearcdc_pkg::CHUNK_W'(step.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len         <= gearcdc_pkg::RST_MIN_LEN;
            r_cfg.avg_len         <= gearcdc_pkg::RST_AVG_LEN;
            r_cfg.max_len         <= gearcdc_pkg::RST_MAX_LEN;
            r_cfg.small_mask_bits <= gearcdc_pkg::RST_SMALL_BITS;
            r_cfg.large_mask_bits <= gearcdc_pkg::RST_LARGE_BITS;
            r_in_valid            <= 1'b0;
            r_fp                  <= '0;
            r_len                 <= '0;
            r_out_valid           <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_in_valid  <= n_in_valid;
            r_fp        <= n_fp;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
        r_in_eos  <= n_in_eos;
        r_out_len <= n_out_len;
    end

`ifndef SYNTHESIS
    // an end-of-stream byte always closes the chunk
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_eos |=> (r_len == '0) && (r_fp == '0) && r_out_valid)
        else $error("end-of-stream byte did not close the chunk");

    // a reported chunk is never empty
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != '0))
        else $error("zero chunk length reported");

    // a held byte is not overwritten before it is hashed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc_fire |=> r_in_valid && $stable(r_in_byte)
                                     && $stable(r_in_eos))
        else $error("input stage lost a byte");
`endif

endmodule

`default_nettype wire
